### hw/rtl/skset_pkg.sv
// Package for the sorted key set: request/result transaction structs,
// request and status codes, and the control struct sent to the key cells.
// No dependencies.
package skset_pkg;

  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  count;
  } out_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the incoming key and rank
    logic ins;  // insert shift toward the tail
    logic del;  // delete shift toward the head
  } cell_ctl_t;

endpackage

### hw/rtl/skset_cell.sv
// One slot of the sorted key chain: holds a key, compares it against the
// broadcast key, and shifts to or from its neighbors on insert/delete.
// Depends on skset_pkg.
module skset_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  skset_pkg::cell_ctl_t        ctl_i,
  input  logic [CW-1:0]               count_i,
  input  logic [skset_pkg::KEY_W-1:0] cmp_key_i,
  input  logic [skset_pkg::RANK_W-1:0] rank_i,
  input  logic [skset_pkg::KEY_W-1:0] upd_key_i,
  input  logic [skset_pkg::KEY_W-1:0] left_key_i,
  input  logic                        left_gt_i,
  input  logic [skset_pkg::KEY_W-1:0] right_key_i,
  output logic [skset_pkg::KEY_W-1:0] key_o,
  output logic                        gt_o,
  output logic                        eq_o,
  output logic [skset_pkg::KEY_W-1:0] sel_key_o
);

  logic [skset_pkg::KEY_W-1:0] key_r, key_nxt;
  logic gt_r, gt_nxt;
  logic eq_r, eq_nxt;
  logic sel_r, sel_nxt;
  logic occupied;

  // Slot holds a live key when its index is below the count
  assign occupied = (CW'(IDX) < count_i);

  // Compare flags, captured when a transaction is accepted
  always_comb begin
    gt_nxt  = gt_r;
    eq_nxt  = eq_r;
    sel_nxt = sel_r;
    if (ctl_i.cmp) begin
      gt_nxt  = occupied && (key_r > cmp_key_i);
      eq_nxt  = occupied && (key_r == cmp_key_i);
      sel_nxt = (int'(rank_i) == IDX);
    end
  end

  // Key update: keep larger keys, otherwise take the new key or shift
  always_comb begin
    key_nxt = key_r;
    if (ctl_i.ins && !gt_r) begin
      if (IDX == 0 || left_gt_i) begin
        key_nxt = upd_key_i;
      end else begin
        key_nxt = left_key_i;
      end
    end else if (ctl_i.del && !gt_r) begin
      key_nxt = right_key_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      gt_r  <= 1'b0;
      eq_r  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      gt_r  <= gt_nxt;
      eq_r  <= eq_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign key_o     = key_r;
  assign gt_o      = gt_r;
  assign eq_o      = eq_r;
  assign sel_key_o = sel_r ? key_r : '0;

endmodule

### hw/rtl/sorted_key_set_unit.sv
// Sorted key set top level: a chain of key cells plus request sequencing
// and the result register. Depends on skset_pkg and skset_cell.
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (insert, delete, or read
//   by rank); each produces exactly one result on out_valid/out_ready/
//   out_data with a status, the read key (0 unless a read succeeds) and
//   the key count after the operation. Keys are held in decreasing order,
//   at most CAPACITY of them, one key per cell.
//   Timing: a transaction accepted at one clock edge moves the unit to
//   S_UPD; its result enters the output register, and out_valid rises,
//   at the commit edge. All cells compare against the incoming key at the
//   accept edge; the shift and status are committed from S_UPD, and
//   in_ready is low during the commit cycle.
//   Stall: if the previous result is still unclaimed, the commit cycle
//   waits until out_ready frees the output register; the cell flags hold
//   meanwhile. A new request may be accepted while a result waits.
//   Reset: rst_n (synchronous, active low) empties the set; stored keys
//   are not cleared and are never read until written.
module sorted_key_set_unit #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  skset_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output skset_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  skset_pkg::in_t req_r;
  logic out_valid_r, out_valid_nxt;
  skset_pkg::out_t out_data_r, out_data_nxt;

  skset_pkg::cell_ctl_t ctl;
  logic in_fire, commit, found, full;
  logic [skset_pkg::KEY_W-1:0] rd_key;
  logic [skset_pkg::KEY_W-1:0] cell_key [CAPACITY];
  logic [skset_pkg::KEY_W-1:0] cell_sel_key [CAPACITY];
  logic [CAPACITY-1:0] gt_vec, eq_vec;
  logic do_ins, do_del;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign commit   = (state_r == S_UPD) && (!out_valid_r || out_ready);

  // Cell chain
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [skset_pkg::KEY_W-1:0] left_key, right_key;
    logic left_gt;
    if (j == 0) begin : g_head
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[j-1];
      assign left_gt  = gt_vec[j-1];
    end
    if (j == CAPACITY - 1) begin : g_tail
      assign right_key = cell_key[j];
    end else begin : g_body
      assign right_key = cell_key[j+1];
    end

    skset_cell #(
      .IDX (j),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl_i       (ctl),
      .count_i     (count_r),
      .cmp_key_i   (in_data.key),
      .rank_i      (in_data.rank),
      .upd_key_i   (req_r.key),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (cell_key[j]),
      .gt_o        (gt_vec[j]),
      .eq_o        (eq_vec[j]),
      .sel_key_o   (cell_sel_key[j])
    );
  end

  // Collect the selected key for a read
  always_comb begin
    rd_key = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rd_key = rd_key | cell_sel_key[j];
    end
  end

  assign found = |eq_vec;
  assign full  = (count_r == CW'(CAPACITY));

  // Decide the operation and build the result
  always_comb begin
    do_ins               = 1'b0;
    do_del               = 1'b0;
    count_nxt            = count_r;
    out_data_nxt         = out_data_r;
    out_data_nxt.status  = skset_pkg::ST_OK;
    out_data_nxt.key_out = '0;
    case (req_r.req_type)
      skset_pkg::REQ_INSERT: begin
        if (found) begin
          out_data_nxt.status = skset_pkg::ST_DUP;
        end else if (full) begin
          out_data_nxt.status = skset_pkg::ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      skset_pkg::REQ_DELETE: begin
        if (found) begin
          do_del    = 1'b1;
          count_nxt = count_r - CW'(1);
        end else begin
          out_data_nxt.status = skset_pkg::ST_NOTFOUND;
        end
      end
      skset_pkg::REQ_READ: begin
        if (32'(req_r.rank) < 32'(count_r)) begin
          out_data_nxt.key_out = rd_key;
        end else begin
          out_data_nxt.status = skset_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    out_data_nxt.count = skset_pkg::COUNT_W'(count_nxt);
  end

  assign ctl.cmp = in_fire;
  assign ctl.ins = commit && do_ins;
  assign ctl.del = commit && do_del;

  // Sequencing and output slot
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/skset_checker.sv
// Port-level checker for sorted_key_set_unit, attached by bind.
// Depends on skset_pkg.
module skset_checker #(
  parameter int CAPACITY = 64
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input skset_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input skset_pkg::out_t out_data
);

  // One request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("skset: transaction accepted during commit cycle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("skset: result changed while stalled");

  // Only a successful operation may carry a key
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != skset_pkg::ST_OK) |-> out_data.key_out == '0)
    else $error("skset: nonzero key on failed request");

  // Status code is a defined one
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= skset_pkg::ST_RANGE)
    else $error("skset: undefined status");

  // Count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.count) <= CAPACITY)
    else $error("skset: count above capacity");

endmodule

bind sorted_key_set_unit skset_checker #(.CAPACITY(CAPACITY)) u_skset_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for sorted_key_set_unit: directed, capacity, back-pressure and
// random request streams, checked against an in-bench model of the sorted key store.
// Depends on skset_pkg and the sorted_key_set_unit RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP         = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int HOLD_LEN    = 60;
  localparam logic [skset_pkg::REQ_W-1:0] REQ_NOP = 2'd3;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  skset_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  skset_pkg::out_t out_data;

  // Model of the key store: keys in decreasing order, first key_total valid
  logic [skset_pkg::KEY_W-1:0] model_keys [CAP];
  int                          key_total;

  skset_pkg::out_t pending_results [$];
  skset_pkg::out_t want_res;
  int   error_count;
  int   stall_cycles;
  int   in_idle_pct;
  int   out_idle_pct;
  int   hold_cycles;

  sorted_key_set_unit #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the model and return the result it should produce
  function automatic skset_pkg::out_t apply_request(input skset_pkg::in_t req);
    skset_pkg::out_t res;
    int              pos;
    res = '0;
    res.status = skset_pkg::ST_OK;
    if (req.req_type == skset_pkg::REQ_INSERT || req.req_type == skset_pkg::REQ_DELETE) begin
      pos = 0;
      while (pos < key_total && model_keys[pos] > req.key) pos++;
      if (req.req_type == skset_pkg::REQ_INSERT) begin
        if (pos < key_total && model_keys[pos] == req.key) begin
          res.status = skset_pkg::ST_DUP;
        end else if (key_total >= CAP) begin
          res.status = skset_pkg::ST_FULL;
        end else begin
          for (int j = key_total; j > pos; j--) model_keys[j] = model_keys[j-1];
          model_keys[pos] = req.key;
          key_total++;
        end
      end else begin
        if (pos < key_total && model_keys[pos] == req.key) begin
          for (int j = pos; j + 1 < key_total; j++) model_keys[j] = model_keys[j+1];
          key_total--;
        end else begin
          res.status = skset_pkg::ST_NOTFOUND;
        end
      end
    end else if (req.req_type == skset_pkg::REQ_READ) begin
      if (int'(req.rank) < key_total) res.key_out = model_keys[req.rank];
      else res.status = skset_pkg::ST_RANGE;
    end
    res.count = skset_pkg::COUNT_W'(key_total);
    return res;
  endfunction

  function automatic skset_pkg::in_t make_req(input logic [skset_pkg::REQ_W-1:0] op,
                                              input logic [skset_pkg::KEY_W-1:0] k,
                                              input logic [skset_pkg::RANK_W-1:0] r);
    skset_pkg::in_t req;
    req.req_type = op;
    req.key      = k;
    req.rank     = r;
    return req;
  endfunction

  // Key source: mostly keys already held or from a small pool, so hits and
  // duplicates are frequent; the rest are extremes or fully random
  function automatic logic [skset_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4 && key_total > 0) return model_keys[$urandom_range(key_total - 1)];
    if (sel < 6) return skset_pkg::KEY_W'($urandom_range(31));
    if (sel == 6) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Send one transaction; entered and left just after a falling edge
  task automatic send_request(input skset_pkg::in_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(req));
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Empty-store cases, extremes, duplicates, range reads, deletes back to empty
  task automatic test_directed();
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'h0,         6'd0));
    send_request(make_req(REQ_NOP,               32'hFFFF_FFFF, 6'h3F));
    send_request(make_req(skset_pkg::REQ_INSERT, 32'h0,         6'h3F));
    send_request(make_req(skset_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd0));
    send_request(make_req(skset_pkg::REQ_INSERT, 32'h8000_0000, 6'd5));
    send_request(make_req(skset_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd0));
    send_request(make_req(skset_pkg::REQ_INSERT, 32'h0,         6'd0));
    send_request(make_req(skset_pkg::REQ_READ,   32'hFFFF_FFFF, 6'd0));
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'd1));
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'd2));
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'd3));
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'h3F));
    send_request(make_req(REQ_NOP,               32'h0,         6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'h8000_0000, 6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'h0000_0005, 6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'h0,         6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'hFFFF_FFFF, 6'd0));
    send_request(make_req(skset_pkg::REQ_DELETE, 32'hFFFF_FFFF, 6'd0));
    send_request(make_req(skset_pkg::REQ_READ,   32'h0,         6'd0));
  endtask

  // Fill to capacity, hit full and duplicate-on-full, then delete everything
  task automatic test_fill_to_capacity();
    while (key_total < CAP)
      send_request(make_req(skset_pkg::REQ_INSERT, $urandom,
                            skset_pkg::RANK_W'($urandom)));
    send_request(make_req(skset_pkg::REQ_INSERT, $urandom, skset_pkg::RANK_W'($urandom)));
    send_request(make_req(skset_pkg::REQ_INSERT, model_keys[10], 6'd0));
    send_request(make_req(skset_pkg::REQ_INSERT, model_keys[CAP-1], 6'd0));
    send_request(make_req(skset_pkg::REQ_READ, 32'h0, 6'd0));
    send_request(make_req(skset_pkg::REQ_READ, 32'h0, 6'h3F));
    send_request(make_req(skset_pkg::REQ_DELETE, model_keys[CAP-1] - 32'd1, 6'd0));
    while (key_total > 0) begin
      if ($urandom_range(3) == 0)
        send_request(make_req(skset_pkg::REQ_READ, $urandom,
                              skset_pkg::RANK_W'($urandom_range(key_total))));
      send_request(make_req(skset_pkg::REQ_DELETE, model_keys[$urandom_range(key_total - 1)],
                            skset_pkg::RANK_W'($urandom)));
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // then the sender pauses until every pending result is back
  task automatic test_backpressure();
    int saved_pct;
    saved_pct   = in_idle_pct;
    in_idle_pct = 0;
    hold_cycles = HOLD_LEN;
    for (int i = 0; i < 12; i++)
      send_request(make_req(($urandom_range(1) == 0) ? skset_pkg::REQ_INSERT
                                                     : skset_pkg::REQ_READ,
                            pick_key(), skset_pkg::RANK_W'($urandom_range(7))));
    stop_input();
    wait (pending_results.size() == 0);
    @(negedge clk);
    in_idle_pct = saved_pct;
  endtask

  // Random mix, alternating between growing and shrinking the set
  task automatic test_random_mix(input int n_items);
    int                          pick;
    int                          ins_pct;
    int                          del_pct;
    bit                          grow;
    logic [skset_pkg::RANK_W-1:0] r;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 120 == 119) grow = !grow;
      ins_pct = grow ? 65 : 20;
      del_pct = grow ? 15 : 60;
      pick    = $urandom_range(99);
      if ($urandom_range(1) == 0 && key_total > 0)
        r = skset_pkg::RANK_W'($urandom_range(key_total));
      else r = skset_pkg::RANK_W'($urandom);
      if (pick < ins_pct)
        send_request(make_req(skset_pkg::REQ_INSERT, pick_key(),
                              skset_pkg::RANK_W'($urandom)));
      else if (pick < ins_pct + del_pct)
        send_request(make_req(skset_pkg::REQ_DELETE, pick_key(),
                              skset_pkg::RANK_W'($urandom)));
      else if (pick < 96)
        send_request(make_req(skset_pkg::REQ_READ, $urandom, r));
      else
        send_request(make_req(REQ_NOP, $urandom, skset_pkg::RANK_W'($urandom)));
    end
  endtask

  // Receiver: random ready, or a forced hold-off counted down here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Result checker: each accepted result against the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: %p", out_data);
        error_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_data.status);
          error_count++;
        end
        if (out_data.key_out !== want_res.key_out) begin
          $error("key_out: expected %h, got %h", want_res.key_out, out_data.key_out);
          error_count++;
        end
        if (out_data.count !== want_res.count) begin
          $error("count: expected %0d, got %0d", want_res.count, out_data.count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    key_total    = 0;
    error_count  = 0;
    stall_cycles = 0;
    hold_cycles  = 0;
    in_idle_pct  = 38;
    out_idle_pct = 56;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_to_capacity();
    test_backpressure();
    test_random_mix(400);

    in_idle_pct  = 56;
    out_idle_pct = 38;
    test_random_mix(400);
    test_backpressure();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_mix(310);

    stop_input();
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sorted_key_set_unit.f
hw/rtl/skset_pkg.sv
hw/rtl/skset_cell.sv
hw/rtl/sorted_key_set_unit.sv
hw/rtl/skset_checker.sv
dv/tb_top.sv
